// ===== rtl/core/ps2ma_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet assembler.
// Used by ps2ma_decode and ps2_mouse_packet_assembler_unit; no dependencies.
`default_nettype none
package ps2ma_pkg;

    // Controller status bits.
    localparam int unsigned ReadyBit = 0;
    localparam int unsigned AuxBit   = 5;

    // Header byte bits of a mouse packet.
    localparam int unsigned StartBit = 3;
    localparam int unsigned XSignBit = 4;
    localparam int unsigned YSignBit = 5;
    localparam int unsigned XOvfBit  = 6;
    localparam int unsigned YOvfBit  = 7;

    // Register indexes of the configuration port.
    localparam logic CFG_WHEEL_MODE = 1'b0;
    localparam logic CFG_TIMEOUT_MS = 1'b1;

    localparam logic [7:0] TimeoutReset = 8'd50;
    localparam logic [7:0] ElapsedMax   = 8'hFF;

    // Request types on the input channel.
    localparam logic REQ_PAIR = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds.
    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_MOUSE = 1'b1;

    // Position of the next mouse byte within a packet.
    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_X      = 4'b0010,
        PH_Y      = 4'b0100,
        PH_WHEEL  = 4'b1000
    } t_phase;

    // Decoded movement of one finished packet.
    typedef struct packed {
        logic signed [8:0] move_x;
        logic signed [9:0] move_y;
        logic signed [7:0] wheel;
    } t_packet;

endpackage
`default_nettype wire

// ===== rtl/core/ps2ma_decode.sv =====
// Packet decoder: turns header, X, Y and wheel bytes into signed movement.
// Depends on ps2ma_pkg for bit positions and the t_packet type.
`default_nettype none
module ps2ma_decode (
    input  wire logic [7:0]         i_header,
    input  wire logic [7:0]         i_x,
    input  wire logic [7:0]         i_y,
    input  wire logic [7:0]         i_fourth,
    input  wire logic               i_wheel_mode,
    output ps2ma_pkg::t_packet      o_packet
);

    logic       w_ovf;
    logic [8:0] w_ox;
    logic [9:0] w_oy;

    assign w_ovf = i_header[ps2ma_pkg::XOvfBit] | i_header[ps2ma_pkg::YOvfBit];

    // Sign extension comes from the header, not from the data bytes.
    assign w_ox = w_ovf ? 9'd0 : {i_header[ps2ma_pkg::XSignBit], i_x};
    assign w_oy = w_ovf ? 10'd0 : {{2{i_header[ps2ma_pkg::YSignBit]}}, i_y};

    assign o_packet.move_x = w_ox;
    assign o_packet.move_y = ~w_oy + 10'd1;
    assign o_packet.wheel  = i_wheel_mode ? i_fourth : 8'd0;

endmodule
`default_nettype wire

// ===== rtl/core/ps2_mouse_packet_assembler_unit.sv =====
// PS/2 mouse packet assembler.
// Throughput one word per cycle; the only stall is a full result register that is not taken.
// Each word passes an input register, one step of the packet state logic, and a result register.
// Reset (i_rst_n low, synchronous) empties both registers, clears the packet state and the
// millisecond counter, and sets wheel_mode to 0 and timeout_ms to 50.
// Depends on ps2ma_pkg and ps2ma_decode.
`default_nettype none
module ps2_mouse_packet_assembler_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [7:0]         i_cfg_data,
    // Input channel.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_req_type,
    input  wire logic [7:0]         i_status_byte,
    input  wire logic [7:0]         i_data_byte,
    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_kind,
    output logic [7:0]              o_scan_code,
    output logic signed [8:0]       o_move_x,
    output logic signed [9:0]       o_move_y,
    output logic [7:0]              o_button_flags,
    output logic signed [7:0]       o_wheel
);

    // Configuration registers.
    logic       r_wheel_mode;
    logic [7:0] r_timeout_ms;

    // Input register: holds one word until the state logic takes it.
    logic       r_in_valid;
    logic       r_req_type;
    logic [7:0] r_status;
    logic [7:0] r_data;

    // Packet state.
    ps2ma_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_header, n_header;
    logic [7:0] r_x, n_x;
    logic [7:0] r_y, n_y;
    logic [7:0] r_elapsed, n_elapsed;

    // Result register.
    logic              r_out_valid;
    logic              r_kind;
    logic [7:0]        r_scan;
    logic signed [8:0] r_move_x;
    logic signed [9:0] r_move_y;
    logic [7:0]        r_flags;
    logic signed [7:0] r_wheel;

    logic               w_adv;
    logic               w_emit;
    logic               w_emit_mouse;
    logic               w_mouse_byte;
    logic [7:0]         w_dec_y;
    ps2ma_pkg::t_packet w_packet;

    // The word in the input register moves on whenever the result register can take
    // whatever it produces. A new word enters as the held one leaves.
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    assign w_mouse_byte = (r_req_type == ps2ma_pkg::REQ_PAIR)
                       && r_status[ps2ma_pkg::ReadyBit] && r_status[ps2ma_pkg::AuxBit];

    // The third byte goes to the decoder directly when it closes a three-byte packet.
    assign w_dec_y = (r_phase == ps2ma_pkg::PH_WHEEL) ? r_y : r_data;

    ps2ma_decode u_decode (
        .i_header     (r_header),
        .i_x          (r_x),
        .i_y          (w_dec_y),
        .i_fourth     (r_data),
        .i_wheel_mode (r_wheel_mode),
        .o_packet     (w_packet)
    );

    // One step of the packet state for the word in the input register.
    always_comb begin
        ps2ma_pkg::t_phase v_phase;
        n_phase      = r_phase;
        n_header     = r_header;
        n_x          = r_x;
        n_y          = r_y;
        n_elapsed    = r_elapsed;
        w_emit       = 1'b0;
        w_emit_mouse = 1'b0;
        v_phase      = r_phase;
        if (r_req_type == ps2ma_pkg::REQ_TICK) begin
            if (r_elapsed != ps2ma_pkg::ElapsedMax) begin
                n_elapsed = r_elapsed + 8'd1;
            end
        end else if (r_status[ps2ma_pkg::ReadyBit]) begin
            if (!r_status[ps2ma_pkg::AuxBit]) begin
                // Keyboard byte passes through; mouse state is untouched.
                w_emit = 1'b1;
            end else begin
                // A packet in progress restarts when the gap ran past the timeout.
                if (r_phase != ps2ma_pkg::PH_HEADER && r_elapsed > r_timeout_ms) begin
                    v_phase = ps2ma_pkg::PH_HEADER;
                end
                n_elapsed = 8'd0;
                unique case (v_phase)
                    ps2ma_pkg::PH_HEADER: begin
                        n_header = r_data;
                        n_phase  = r_data[ps2ma_pkg::StartBit] ? ps2ma_pkg::PH_X
                                                               : ps2ma_pkg::PH_HEADER;
                    end
                    ps2ma_pkg::PH_X: begin
                        n_x     = r_data;
                        n_phase = ps2ma_pkg::PH_Y;
                    end
                    ps2ma_pkg::PH_Y: begin
                        n_y = r_data;
                        if (r_wheel_mode) begin
                            n_phase = ps2ma_pkg::PH_WHEEL;
                        end else begin
                            n_phase      = ps2ma_pkg::PH_HEADER;
                            w_emit       = 1'b1;
                            w_emit_mouse = 1'b1;
                        end
                    end
                    ps2ma_pkg::PH_WHEEL: begin
                        n_phase      = ps2ma_pkg::PH_HEADER;
                        w_emit       = 1'b1;
                        w_emit_mouse = 1'b1;
                    end
                    default: begin
                        n_phase = ps2ma_pkg::PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wheel_mode <= 1'b0;
            r_timeout_ms <= ps2ma_pkg::TimeoutReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ps2ma_pkg::CFG_WHEEL_MODE: r_wheel_mode <= i_cfg_data[0];
                ps2ma_pkg::CFG_TIMEOUT_MS: r_timeout_ms <= i_cfg_data;
                default: r_wheel_mode <= r_wheel_mode;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req_type <= i_req_type;
            r_status   <= i_status_byte;
            r_data     <= i_data_byte;
        end
    end

    // Packet state advances only when the held word is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ps2ma_pkg::PH_HEADER;
            r_header  <= 8'd0;
            r_x       <= 8'd0;
            r_y       <= 8'd0;
            r_elapsed <= 8'd0;
        end else if (w_adv) begin
            r_phase   <= n_phase;
            r_header  <= n_header;
            r_x       <= n_x;
            r_y       <= n_y;
            r_elapsed <= n_elapsed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            if (w_emit_mouse) begin
                r_kind   <= ps2ma_pkg::KIND_MOUSE;
                r_scan   <= 8'd0;
                r_move_x <= w_packet.move_x;
                r_move_y <= w_packet.move_y;
                r_flags  <= r_header;
                r_wheel  <= w_packet.wheel;
            end else begin
                r_kind   <= ps2ma_pkg::KIND_KEY;
                r_scan   <= r_data;
                r_move_x <= 9'sd0;
                r_move_y <= 10'sd0;
                r_flags  <= 8'd0;
                r_wheel  <= 8'sd0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_scan_code    = r_scan;
    assign o_move_x       = r_move_x;
    assign o_move_y       = r_move_y;
    assign o_button_flags = r_flags;
    assign o_wheel        = r_wheel;

    // A keyboard result carries only the scan byte.
    a_key_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == ps2ma_pkg::KIND_KEY) |->
            (o_move_x == 9'sd0 && o_move_y == 10'sd0 && o_button_flags == 8'd0
             && o_wheel == 8'sd0))
        else $error("keyboard result carries mouse fields");

    // A mouse result with an overflow flag reports no X or Y movement.
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == ps2ma_pkg::KIND_MOUSE
         && (o_button_flags[ps2ma_pkg::XOvfBit] || o_button_flags[ps2ma_pkg::YOvfBit]))
            |-> (o_move_x == 9'sd0 && o_move_y == 10'sd0 && o_scan_code == 8'd0))
        else $error("overflowed packet reports movement");

    // Every consumed mouse byte restarts the gap counter.
    a_gap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_mouse_byte) |=> (r_elapsed == 8'd0))
        else $error("gap counter not cleared by mouse byte");

    // A packet in progress never sits in a phase beyond the header without a start header.
    a_start_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != ps2ma_pkg::PH_HEADER) |-> r_header[ps2ma_pkg::StartBit])
        else $error("packet in progress without start bit in header");

endmodule
`default_nettype wire
